@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, sampled on i_clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property check on the local i_clk / i_rst_n pair
`define NESFC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Expression that must never be true at a clock edge
`define NESFC_NEVER(lbl, expr, msg) \
    `NESFC_ASSERT(lbl, !(expr), msg)

`endif

@@ rtl/nesfc_pkg.sv @@
// ----------------------------------------------------------------------------
// nesfc_pkg
// Shared widths, word types, microcode control word and condition codes.
// ----------------------------------------------------------------------------
package nesfc_pkg;

    // Width of row and fold counts
    localparam int COUNT_BITS = 20;
    // Divider bit counter width
    localparam int CNT_W = $clog2(COUNT_BITS);
    // Microcode address width
    localparam int UPC_W = 4;

    // Jump condition codes
    localparam logic [2:0] C_NEVER   = 3'd0;
    localparam logic [2:0] C_ALWAYS  = 3'd1;
    localparam logic [2:0] C_NOSTART = 3'd2;
    localparam logic [2:0] C_EQ      = 3'd3;
    localparam logic [2:0] C_D_DONE  = 3'd4;
    localparam logic [2:0] C_DIVMORE = 3'd5;
    localparam logic [2:0] C_HIT     = 3'd6;

    typedef struct packed {
        logic [COUNT_BITS-1:0] row_count;
        logic [COUNT_BITS-1:0] requested_folds;
    } t_in_word;

    typedef struct packed {
        logic [COUNT_BITS-1:0] chosen_folds;
        logic                  folds_changed;
    } t_out_word;

    // One microcode control word
    typedef struct packed {
        logic [2:0]       cond;
        logic [UPC_W-1:0] target;
        logic             load;
        logic             init;
        logic             div_init;
        logic             div_step;
        logic             cand;
        logic             eval;
        logic             emit_k;
        logic             emit_best;
    } t_uword;

    // Datapath flags seen by the sequencer
    typedef struct packed {
        logic eq;
        logic d_done;
        logic div_more;
        logic hit;
    } t_dp_stat;

endpackage

@@ rtl/nesfc_seq.sv @@
// ----------------------------------------------------------------------------
// nesfc_seq
// Microcode sequencer: step counter, program ROM and conditional jumps.
// ----------------------------------------------------------------------------
module nesfc_seq import nesfc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_uword   o_uword,
    output logic     o_busy
);

    // Program step addresses
    localparam logic [UPC_W-1:0] S_IDLE  = 4'd0;
    localparam logic [UPC_W-1:0] S_CHKEQ = 4'd1;
    localparam logic [UPC_W-1:0] S_TEST  = 4'd2;
    localparam logic [UPC_W-1:0] S_DIV   = 4'd3;
    localparam logic [UPC_W-1:0] S_CAND  = 4'd4;
    localparam logic [UPC_W-1:0] S_EVAL  = 4'd5;
    localparam logic [UPC_W-1:0] S_LOOP  = 4'd6;
    localparam logic [UPC_W-1:0] S_EMITK = 4'd7;
    localparam logic [UPC_W-1:0] S_EMITB = 4'd8;

    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_uword           w_uw;
    logic             w_take;

    // Program ROM
    function automatic t_uword rom(input logic [UPC_W-1:0] a);
        t_uword u;
        u = '0;
        u.cond = C_NEVER;
        u.target = S_IDLE;
        case (a)
            S_IDLE: begin
                u.load = 1'b1;
                u.cond = C_NOSTART;
                u.target = S_IDLE;
            end
            S_CHKEQ: begin
                u.init = 1'b1;
                u.cond = C_EQ;
                u.target = S_EMITK;
            end
            S_TEST: begin
                u.div_init = 1'b1;
                u.cond = C_D_DONE;
                u.target = S_EMITB;
            end
            S_DIV: begin
                u.div_step = 1'b1;
                u.cond = C_DIVMORE;
                u.target = S_DIV;
            end
            S_CAND: begin
                u.cand = 1'b1;
            end
            S_EVAL: begin
                u.eval = 1'b1;
                u.cond = C_HIT;
                u.target = S_EMITK;
            end
            S_LOOP: begin
                u.cond = C_ALWAYS;
                u.target = S_TEST;
            end
            S_EMITK: begin
                u.emit_k = 1'b1;
                u.cond = C_ALWAYS;
                u.target = S_IDLE;
            end
            S_EMITB: begin
                u.emit_best = 1'b1;
                u.cond = C_ALWAYS;
                u.target = S_IDLE;
            end
            default: begin
                u.cond = C_ALWAYS;
                u.target = S_IDLE;
            end
        endcase
        return u;
    endfunction

    assign w_uw = rom(r_upc);

    // Jump condition select
    always_comb begin
        case (w_uw.cond)
            C_NEVER:   w_take = 1'b0;
            C_ALWAYS:  w_take = 1'b1;
            C_NOSTART: w_take = !i_start;
            C_EQ:      w_take = i_stat.eq;
            C_D_DONE:  w_take = i_stat.d_done;
            C_DIVMORE: w_take = i_stat.div_more;
            C_HIT:     w_take = i_stat.hit;
            default:   w_take = 1'b1;
        endcase
        n_upc = w_take ? w_uw.target : r_upc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_uword = w_uw;
    assign o_busy  = (r_upc != S_IDLE);

endmodule

@@ rtl/nesfc_dp.sv @@
// ----------------------------------------------------------------------------
// nesfc_dp
// Datapath: serial restoring divider, round-half-even, best-candidate track.
// ----------------------------------------------------------------------------
module nesfc_dp import nesfc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_word  i_word,
    input  t_uword    i_uword,
    output t_dp_stat  o_stat,
    output t_out_word o_word,
    output logic      o_done
);

    localparam int CB = COUNT_BITS;

    logic [CB-1:0]    r_n, r_k, r_best, r_best_gap, r_d;
    logic [CB-1:0]    r_rem, r_quo, r_cand;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    t_out_word        r_out;

    logic [CB:0]   w_shift, w_diff, w_twice;
    logic          w_up;
    logic [CB-1:0] w_gap, w_init_gap;

    function automatic logic [CB-1:0] abs_gap(input logic [CB-1:0] a,
                                              input logic [CB-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // One restoring divide step
    assign w_shift = {r_rem, r_quo[CB-1]};
    assign w_diff  = w_shift - {1'b0, r_d};

    // Round half to even from quotient and remainder
    assign w_twice = {r_rem, 1'b0};
    assign w_up    = (w_twice > {1'b0, r_d}) || ((w_twice == {1'b0, r_d}) && r_quo[0]);

    assign w_gap      = abs_gap(r_cand, r_k);
    assign w_init_gap = abs_gap(r_n, r_k);

    // Status flags
    assign o_stat.eq       = (r_n == r_k);
    assign o_stat.d_done   = (r_d > (r_n >> 1));
    assign o_stat.div_more = (r_cnt != CNT_W'(CB - 1));
    assign o_stat.hit      = (w_gap == '0);

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_uword.load && i_start) begin
            r_n <= i_word.row_count;
            r_k <= i_word.requested_folds;
        end
        if (i_uword.init) begin
            r_best     <= r_n;
            r_best_gap <= w_init_gap;
            r_d        <= CB'(2);
        end
        if (i_uword.div_init) begin
            r_rem <= '0;
            r_quo <= r_n;
            r_cnt <= '0;
        end
        if (i_uword.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (!w_diff[CB]) begin
                r_rem <= w_diff[CB-1:0];
                r_quo <= {r_quo[CB-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[CB-1:0];
                r_quo <= {r_quo[CB-2:0], 1'b0};
            end
        end
        if (i_uword.cand) begin
            r_cand <= r_quo + CB'(w_up);
        end
        // Keep the earliest candidate at the smallest distance
        if (i_uword.eval) begin
            r_d <= r_d + 1'b1;
            if (w_gap < r_best_gap) begin
                r_best     <= r_cand;
                r_best_gap <= w_gap;
            end
        end
        if (i_uword.emit_k) begin
            r_out.chosen_folds  <= r_k;
            r_out.folds_changed <= 1'b0;
        end else if (i_uword.emit_best) begin
            r_out.chosen_folds  <= r_best;
            r_out.folds_changed <= (r_best != r_k);
        end
    end

    // Result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_uword.emit_k || i_uword.emit_best;
        end
    end

    assign o_word = r_out;
    assign o_done = r_done;

endmodule

@@ rtl/nearest_even_split_fold_count.sv @@
// Flow: when the row count equals the request, CHKEQ jumps to EMITK and the request
// is returned unchanged; otherwise m = floor(n/2) - 1 denominators are scanned, each
// through TEST, DIV, CAND, EVAL and LOOP, stopping early when one hits the request.
// Handshake: one word at a time, next start taken on the strobe cycle; the serial
// divider (one quotient bit per cycle) governs how soon the next word is taken.
// Reset: synchronous active low, returns the sequencer to idle, no strobe.
// ----------------------------------------------------------------------------
// nearest_even_split_fold_count
// Chooses a fold count near the request that splits the rows evenly, using a
// microcoded sequencer over a serial divide datapath.
// ----------------------------------------------------------------------------
module nearest_even_split_fold_count import nesfc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_word  i_word,
    output t_out_word o_word,
    output logic      o_done
);

    t_uword   w_uword;
    t_dp_stat w_stat;
    logic     w_start;

    assign w_start = start && !busy;

    // Program sequencer
    nesfc_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_stat  (w_stat),
        .o_uword (w_uword),
        .o_busy  (busy)
    );

    // Arithmetic datapath
    nesfc_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_word  (i_word),
        .i_uword (w_uword),
        .o_stat  (w_stat),
        .o_word  (o_word),
        .o_done  (o_done)
    );

endmodule

@@ rtl/nesfc_chk.sv @@
// ----------------------------------------------------------------------------
// nesfc_chk
// Port-level checks on the handshake and result timing, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nesfc_chk import nesfc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_word  i_word,
    input t_out_word o_word,
    input logic      o_done
);

    // An accepted word makes the block busy
    `NESFC_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")

    // A result only follows a busy cycle
    `NESFC_ASSERT(a_done_after_busy, o_done |-> $past(busy), "result strobe without work")

    // The result strobe is never raised directly after another strobe
    `NESFC_NEVER(a_done_twice, o_done && $past(o_done), "result strobe held two cycles")

    // Equal request returns unchanged with a result strobe
    `NESFC_ASSERT(a_equal_fast, (start && !busy && i_word.row_count == i_word.requested_folds) |-> ##3 (o_done && !o_word.folds_changed), "equal request not returned unchanged")

endmodule

bind nearest_even_split_fold_count nesfc_chk u_chk (.*);
